// File: design/radix_integer_text_parser_top_assert.svh
// ----------------------------------------------------------------------------
// radix integer text parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TEXT_PARSER_TOP_ASSERT_SVH
`define RADIX_INTEGER_TEXT_PARSER_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define RIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define RIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rip_pkg.sv
// ----------------------------------------------------------------------------
// rip_pkg
// types, character codes and digit classification for the text parser
// ----------------------------------------------------------------------------
package rip_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned RadixW = 6;
  localparam int unsigned DigitW = 6;
  localparam int unsigned ProdW  = ValueW + RadixW;

  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_LZ    = 8'h7a;
  localparam logic [7:0] CHR_UA    = 8'h41;
  localparam logic [7:0] CHR_UZ    = 8'h5a;

  localparam logic [RadixW-1:0] RADIX_RESET = 6'd10;
  localparam logic [RadixW-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RadixW-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DigitW-1:0] ALPHA_BASE  = 6'd10;

  // one classified character on its way to the accumulator
  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              digit_ok;
    logic              is_minus;
    logic              is_last;
  } rip_item_t;

  function automatic logic [RadixW-1:0] clamp_radix(input logic [RadixW-1:0] r);
    logic [RadixW-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic rip_item_t classify(input logic [7:0] c, input logic [RadixW-1:0] base,
                                         input logic last);
    rip_item_t  it;
    logic [7:0] d;
    logic       is_dig;
    d      = 8'd0;
    is_dig = 1'b1;
    if (c inside {[CHR_ZERO:CHR_NINE]}) begin
      d = c - CHR_ZERO;
    end else if (c inside {[CHR_LA:CHR_LZ]}) begin
      d = c - CHR_LA + 8'(ALPHA_BASE);
    end else if (c inside {[CHR_UA:CHR_UZ]}) begin
      d = c - CHR_UA + 8'(ALPHA_BASE);
    end else begin
      is_dig = 1'b0;
    end
    it.digit    = d[DigitW-1:0];
    it.digit_ok = is_dig && (d < 8'(base));
    it.is_minus = (c == CHR_MINUS);
    it.is_last  = last;
    return it;
  endfunction

endpackage

// File: design/rip_front.sv
// ----------------------------------------------------------------------------
// rip_front
// takes characters and tags them with digit value and legality
// ----------------------------------------------------------------------------
module rip_front import rip_pkg::*; (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_code,
  input  logic              in_is_last,
  input  logic [RadixW-1:0] base,
  output logic              push,
  output rip_item_t         push_item,
  input  logic              q_full
);

  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;
  assign push_item = classify(in_char_code, base, in_is_last);

endmodule

// File: design/rip_queue.sv
// ----------------------------------------------------------------------------
// rip_queue
// two-entry queue between classifier and accumulator
// ----------------------------------------------------------------------------
module rip_queue import rip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rip_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output rip_item_t head_item
);

  rip_item_t  slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/rip_back.sv
// ----------------------------------------------------------------------------
// rip_back
// multiply-add accumulator and registered result stage
// ----------------------------------------------------------------------------
module rip_back import rip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RadixW-1:0] base,
  input  logic              head_valid,
  input  rip_item_t         head_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] out_value,
  output logic              out_valid_res,
  output logic              out_overflowed
);

  logic [ValueW-1:0] acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic              first_r, first_nxt;
  logic              bad_r, bad_nxt;
  logic              wrap_r, wrap_nxt;
  logic              out_valid_r;
  logic [ValueW-1:0] out_value_r;
  logic              out_valid_res_r, out_ovf_r;

  logic [ProdW-1:0]  sum;
  logic              take_minus, take_digit;

  // a non-final beat never needs the result register
  assign pop = head_valid && (!head_item.is_last || !out_valid_r || out_ready);

  assign sum = (ProdW'(acc_r) * ProdW'(base)) + ProdW'(head_item.digit);

  always_comb begin
    take_minus = !bad_r && first_r && head_item.is_minus;
    take_digit = !bad_r && !take_minus && head_item.digit_ok;
    acc_nxt    = take_digit ? sum[ValueW-1:0] : acc_r;
    wrap_nxt   = wrap_r | (take_digit && (sum[ProdW-1:ValueW] != '0));
    neg_nxt    = neg_r | take_minus;
    bad_nxt    = bad_r | (!bad_r && !take_minus && !head_item.digit_ok);
    first_nxt  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      neg_r       <= 1'b0;
      first_r     <= 1'b1;
      bad_r       <= 1'b0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && head_item.is_last) begin
        acc_r       <= '0;
        neg_r       <= 1'b0;
        first_r     <= 1'b1;
        bad_r       <= 1'b0;
        wrap_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (pop) begin
          acc_r   <= acc_nxt;
          neg_r   <= neg_nxt;
          first_r <= first_nxt;
          bad_r   <= bad_nxt;
          wrap_r  <= wrap_nxt;
        end
        if (out_ready) out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.is_last) begin
      if (bad_nxt) begin
        out_value_r     <= '0;
        out_valid_res_r <= 1'b0;
        out_ovf_r       <= 1'b0;
      end else begin
        out_value_r     <= neg_nxt ? (ValueW'(0) - acc_nxt) : acc_nxt;
        out_valid_res_r <= 1'b1;
        out_ovf_r       <= wrap_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_valid_res  = out_valid_res_r;
  assign out_overflowed = out_ovf_r;

endmodule

// File: design/radix_integer_text_parser_top.sv
// ----------------------------------------------------------------------------
// radix_integer_text_parser_top
// ascii signed integer parser, base 2 to 36
// ----------------------------------------------------------------------------
// Takes one ASCII character per input beat, with in_is_last on the final
// character of a number, and gives one result beat per number: the 64-bit
// two's complement value, a valid flag and an overflow flag. A leading minus
// is allowed; digits are 0-9 then a-z or A-Z for 10..35, each below the base
// held in the radix register (values below 2 act as 2, above 36 act as 36).
// Any other character makes the number invalid, which reports value 0 and no
// overflow. The accumulator wraps modulo 2^64 and flags it. One character is
// taken per clock cycle, sustained, while no result waits on out_ready: the
// limit is the combinational 64x6 multiply-add in the accumulator loop. A
// result is offered in the cycle after its last character is taken by the
// accumulator, behind the queue register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module radix_integer_text_parser_top import rip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [RadixW-1:0] cfg_wdata,
  // character beats
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_code,
  input  logic              in_is_last,
  // result beats
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] out_value,
  output logic              out_valid_res,
  output logic              out_overflowed
);

  // radix kept already clamped to the legal range
  logic [RadixW-1:0] radix_r;

  // classifier to queue
  logic      push;
  rip_item_t push_item;
  logic      q_full;

  // queue to accumulator
  logic      pop;
  logic      head_valid;
  rip_item_t head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= clamp_radix(cfg_wdata);
    end
  end

  // front: accept and tag each character
  rip_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .base         (radix_r),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // short queue so a stalled result does not stop intake at once
  rip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: accumulate and hold the result until taken
  rip_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .base           (radix_r),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_valid_res  (out_valid_res),
    .out_overflowed (out_overflowed)
  );

endmodule

// File: design/rip_checker.sv
// ----------------------------------------------------------------------------
// rip_checker
// port-level checks on the parser result channel
// ----------------------------------------------------------------------------
`include "radix_integer_text_parser_top_assert.svh"

module rip_checker import rip_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ValueW-1:0] out_value,
  input logic              out_valid_res,
  input logic              out_overflowed
);

  // a stalled result beat stays offered
  `RIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")

  // an invalid number reports zero and no overflow
  `RIP_ASSERT_NOW(a_bad_zero, clk, rst_n, out_valid && !out_valid_res, (out_value == '0) && !out_overflowed, "invalid result not cleared")

  // overflow is only reported on a valid number
  `RIP_ASSERT_NOW(a_ovf_valid, clk, rst_n, out_valid && out_overflowed, out_valid_res, "overflow on invalid result")

  // no result right after reset
  `RIP_ASSERT_NOW(a_reset_idle, clk, rst_n, $past(!rst_n), !out_valid, "result after reset")

endmodule

bind radix_integer_text_parser_top rip_checker u_rip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_value      (out_value),
  .out_valid_res  (out_valid_res),
  .out_overflowed (out_overflowed)
);
